// ----- hw/rtl/ids_pkg.sv -----
// Shared constants, types and codes of the integer domain store.
package ids_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int CAPACITY    = 64;
	localparam int MAX_RESULTS = 33;
	localparam int CMD_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int SIZE_W      = VALUE_BITS + 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int RN_W        = $clog2(MAX_RESULTS + 2);
	localparam int RA_W        = $clog2(MAX_RESULTS);

	typedef logic signed [VALUE_BITS-1:0] value_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD     = 4'd0,
		CMD_EMPTY    = 4'd1,
		CMD_INSERT   = 4'd2,
		CMD_RM_BELOW = 4'd3,
		CMD_RM_ABOVE = 4'd4,
		CMD_RM_VALUE = 4'd5,
		CMD_FIX      = 4'd6,
		CMD_CONTAINS = 4'd7,
		CMD_RUNS     = 4'd8,
		CMD_READ     = 4'd9
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

endpackage

// ----- hw/rtl/ids_if.sv -----
// Command and result channel interfaces of the integer domain store.
interface ids_in_if;
	logic                         valid;
	logic                         ready;
	logic [ids_pkg::CMD_W-1:0]    command;
	logic signed [ids_pkg::VALUE_BITS-1:0] value_a;
	logic signed [ids_pkg::VALUE_BITS-1:0] value_b;

	modport source(output valid, command, value_a, value_b, input ready);
	modport sink(input valid, command, value_a, value_b, output ready);
endinterface

interface ids_out_if;
	logic                         valid;
	logic                         ready;
	logic [ids_pkg::STATUS_W-1:0] status;
	logic                         found;
	logic                         is_interval;
	logic signed [ids_pkg::VALUE_BITS-1:0] lower_bound;
	logic signed [ids_pkg::VALUE_BITS-1:0] upper_bound;
	logic [ids_pkg::SIZE_W-1:0]   domain_size;
	logic                         run_valid;
	logic signed [ids_pkg::VALUE_BITS-1:0] run_low;
	logic signed [ids_pkg::VALUE_BITS-1:0] run_high;
	logic                         last;

	modport source(output valid, status, found, is_interval, lower_bound, upper_bound,
		domain_size, run_valid, run_low, run_high, last, input ready);
	modport sink(input valid, status, found, is_interval, lower_bound, upper_bound,
		domain_size, run_valid, run_low, run_high, last, output ready);
endinterface

// ----- hw/rtl/ids_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ids_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/integer_domain_store.sv -----
// Top level of the integer domain store: sequencer, value store walk and result output.
// Steps: a command is accepted in S_IDLE, set up in S_SETUP, walks the stored values if needed and,
// for a store, reads its first and last value to refresh the bounds (S_FIN0 to S_FIN2); each result
// then passes S_EMRD and S_EMLD, waiting there while the output holds an untaken result. Insert
// into an interval first fills the store, one value per cycle, up to CAPACITY - 1 values.
// One command at a time: a new command is accepted only in S_IDLE.
// Reset is asynchronous and gives the interval [0, 0]; the store needs no clearing pass.
module integer_domain_store (
	input logic clk,
	input logic arst_n,
	ids_in_if.sink   req,
	ids_out_if.source rsp
);
	import ids_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_SETUP  = 11'b00000000010,
		S_FILL   = 11'b00000000100,
		S_WALK   = 11'b00000001000,
		S_WTAIL  = 11'b00000010000,
		S_RUNEND = 11'b00000100000,
		S_FIN0   = 11'b00001000000,
		S_FIN1   = 11'b00010000000,
		S_FIN2   = 11'b00100000000,
		S_EMRD   = 11'b01000000000,
		S_EMLD   = 11'b10000000000
	} state_t;

	typedef enum logic [2:0] {
		W_INS  = 3'd0,
		W_RMLO = 3'd1,
		W_RMHI = 3'd2,
		W_RMV  = 3'd3,
		W_HAS  = 3'd4,
		W_RUN  = 3'd5
	} walk_t;

	state_t state_q, state_d;
	walk_t wop_q, wop_d;
	logic [CMD_W-1:0] cmd_q, cmd_d;
	value_t a_q, a_d, b_q, b_d, lo_q, lo_d, hi_q, hi_d;
	value_t fv_q, fv_d, start_q, start_d, prev_q, prev_d;
	logic mode_q, mode_d, emp_q, emp_d, over_q, over_d, found_q, found_d;
	logic fwd_q, fwd_d, rd_on_q, rd_on_d, ph_q, ph_d, open_q, open_d, skip_q, skip_d;
	logic vld_s1, vld_d;
	logic [IDX_W-1:0] idx_s1, idx_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, rd_idx_q, rd_idx_d, k_q, k_d;
	logic [RN_W-1:0] rn_q, rn_d;
	logic [RA_W-1:0] e_q, e_d;

	logic st_we;
	logic [IDX_W-1:0] st_waddr, st_raddr;
	logic [VALUE_BITS-1:0] st_wdata, st_rdata;
	logic rn_we;
	logic [2*VALUE_BITS-1:0] rn_wdata, rn_rdata;

	value_t v;
	logic [SIZE_W-1:0] size_w, gapd;
	logic gap, last_el, load, last_w, over_w;
	logic [RN_W-1:0] nres_m1;
	logic add_en;
	value_t add_lo, add_hi;

	logic ov_q;
	logic [STATUS_W-1:0] o_status;
	logic o_found, o_mode, o_rv, o_last;
	value_t o_lo, o_hi, o_rlo, o_rhi;
	logic [SIZE_W-1:0] o_size;

	assign v = value_t'(st_rdata);
	assign size_w = {hi_q[VALUE_BITS-1], hi_q} - {lo_q[VALUE_BITS-1], lo_q} + SIZE_W'(1);
	assign gapd = {v[VALUE_BITS-1], v} - {prev_q[VALUE_BITS-1], prev_q};
	assign gap = (v > prev_q) && (gapd > SIZE_W'(1));
	assign last_el = fwd_q ? (CNT_W'(idx_s1) == cnt_q - CNT_W'(1)) : (idx_s1 == '0);
	assign over_w = over_q || (rn_q > RN_W'(MAX_RESULTS));
	assign nres_m1 = (rn_q == '0) ? '0 :
		((rn_q > RN_W'(MAX_RESULTS)) ? RN_W'(MAX_RESULTS - 1) : rn_q - RN_W'(1));
	assign last_w = (rn_q == '0) || (RN_W'(e_q) == nres_m1);
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		logic brk;
		logic [CNT_W-1:0] kn;
		brk = 1'b0;
		kn = k_q;
		state_d = state_q; wop_d = wop_q; cmd_d = cmd_q;
		a_d = a_q; b_d = b_q; lo_d = lo_q; hi_d = hi_q;
		fv_d = fv_q; start_d = start_q; prev_d = prev_q;
		mode_d = mode_q; emp_d = emp_q; over_d = over_q; found_d = found_q;
		fwd_d = fwd_q; rd_on_d = rd_on_q; ph_d = ph_q; open_d = open_q; skip_d = skip_q;
		cnt_d = cnt_q; rd_idx_d = rd_idx_q; k_d = k_q; rn_d = rn_q; e_d = e_q;
		vld_d = 1'b0; idx_d = rd_idx_q[IDX_W-1:0];
		st_we = 1'b0; st_waddr = '0; st_wdata = '0;
		st_raddr = rd_idx_q[IDX_W-1:0];
		add_en = 1'b0; add_lo = '0; add_hi = '0;
		load = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd_d = req.command; a_d = req.value_a; b_d = req.value_b;
					over_d = 1'b0; found_d = 1'b0; rn_d = '0; e_d = '0;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				state_d = S_FIN0;
				k_d = '0; ph_d = 1'b0; open_d = 1'b0;
				case (cmd_q)
					CMD_LOAD: begin
						mode_d = 1'b1; lo_d = a_q; hi_d = b_q; cnt_d = '0;
						emp_d = (a_q > b_q);
					end
					CMD_EMPTY: begin
						mode_d = 1'b0; cnt_d = '0; emp_d = 1'b1;
					end
					CMD_INSERT: begin
						if (mode_q && !emp_q) begin
							if (size_w >= SIZE_W'(CAPACITY)) begin
								over_d = 1'b1;
							end else begin
								fv_d = lo_q; skip_d = 1'b0; state_d = S_FILL;
							end
						end else if (emp_q) begin
							st_we = 1'b1; st_waddr = '0; st_wdata = a_q;
							mode_d = 1'b0; cnt_d = CNT_W'(1); emp_d = 1'b0;
						end else if (cnt_q >= CNT_W'(CAPACITY)) begin
							over_d = 1'b1;
						end else begin
							wop_d = W_INS; fwd_d = 1'b0; rd_idx_d = cnt_q - CNT_W'(1);
							rd_on_d = 1'b1; state_d = S_WALK;
						end
					end
					CMD_RM_BELOW: begin
						if (emp_q) begin
						end else if (a_q > hi_q) begin
							emp_d = 1'b1;
							if (!mode_q) cnt_d = '0;
						end else if (mode_q) begin
							if (a_q > lo_q) lo_d = a_q;
						end else begin
							wop_d = W_RMLO; fwd_d = 1'b1; rd_idx_d = '0;
							rd_on_d = 1'b1; state_d = S_WALK;
						end
					end
					CMD_RM_ABOVE: begin
						if (emp_q) begin
						end else if (a_q < lo_q) begin
							emp_d = 1'b1;
							if (!mode_q) cnt_d = '0;
						end else if (mode_q) begin
							if (a_q < hi_q) hi_d = a_q;
						end else begin
							wop_d = W_RMHI; fwd_d = 1'b0; rd_idx_d = cnt_q - CNT_W'(1);
							rd_on_d = 1'b1; state_d = S_WALK;
						end
					end
					CMD_RM_VALUE: begin
						if (emp_q || a_q < lo_q || hi_q < a_q) begin
						end else if (!mode_q) begin
							wop_d = W_RMV; fwd_d = 1'b1; rd_idx_d = '0;
							rd_on_d = 1'b1; state_d = S_WALK;
						end else if (lo_q == hi_q) begin
							emp_d = 1'b1;
						end else if (a_q == lo_q) begin
							lo_d = a_q + value_t'(1);
						end else if (a_q == hi_q) begin
							hi_d = a_q - value_t'(1);
						end else if (size_w > SIZE_W'(CAPACITY + 1)) begin
							over_d = 1'b1;
						end else begin
							fv_d = lo_q; skip_d = 1'b1; state_d = S_FILL;
						end
					end
					CMD_FIX: begin
						if (!mode_q) begin
							st_we = 1'b1; st_waddr = '0; st_wdata = a_q;
							cnt_d = CNT_W'(1);
						end
						lo_d = a_q; hi_d = a_q; emp_d = 1'b0;
					end
					CMD_CONTAINS: begin
						if (emp_q) begin
						end else if (mode_q) begin
							found_d = (lo_q <= a_q) && (a_q <= hi_q);
						end else begin
							wop_d = W_HAS; fwd_d = 1'b1; rd_idx_d = '0;
							rd_on_d = 1'b1; state_d = S_WALK;
						end
					end
					CMD_RUNS: begin
						if (emp_q) begin
						end else if (mode_q) begin
							if (!(lo_q <= a_q && b_q <= hi_q)) begin
								add_en = 1'b1;
								add_lo = (lo_q > a_q) ? lo_q : a_q;
								add_hi = (hi_q < b_q) ? hi_q : b_q;
							end
						end else if (!(lo_q <= a_q && b_q <= hi_q &&
							size_w == SIZE_W'(cnt_q))) begin
							wop_d = W_RUN; fwd_d = 1'b1; rd_idx_d = '0;
							rd_on_d = 1'b1; state_d = S_WALK;
						end
					end
					default: begin
					end
				endcase
			end
			S_FILL: begin
				if (!(skip_q && fv_q == a_q)) begin
					st_we = 1'b1; st_waddr = k_q[IDX_W-1:0]; st_wdata = fv_q;
					kn = k_q + CNT_W'(1);
				end
				k_d = kn;
				if (fv_q == hi_q) begin
					mode_d = 1'b0; cnt_d = kn; emp_d = (kn == '0);
					state_d = (cmd_q == CMD_INSERT) ? S_SETUP : S_FIN0;
				end else begin
					fv_d = fv_q + value_t'(1);
				end
			end
			S_WALK: begin
				st_raddr = rd_idx_q[IDX_W-1:0];
				if (rd_on_q) begin
					vld_d = 1'b1;
					if (fwd_q ? (rd_idx_q == cnt_q - CNT_W'(1)) : (rd_idx_q == '0)) begin
						rd_on_d = 1'b0;
					end else begin
						rd_idx_d = fwd_q ? rd_idx_q + CNT_W'(1) : rd_idx_q - CNT_W'(1);
					end
				end
				if (vld_s1) begin
					prev_d = v;
					unique case (wop_q)
						W_INS: begin
							st_we = 1'b1;
							st_waddr = IDX_W'(CNT_W'(idx_s1) + CNT_W'(1));
							if (v > a_q) begin
								st_wdata = v;
								if (idx_s1 == '0) state_d = S_WTAIL;
							end else begin
								st_wdata = a_q;
								cnt_d = cnt_q + CNT_W'(1); emp_d = 1'b0;
								state_d = S_FIN0;
							end
						end
						W_RMLO: begin
							if (!ph_q && v < a_q) begin
								k_d = k_q + CNT_W'(1);
							end else begin
								ph_d = 1'b1;
								st_we = 1'b1;
								st_waddr = IDX_W'(CNT_W'(idx_s1) - k_q);
								st_wdata = v;
							end
							if (last_el) begin
								cnt_d = cnt_q - k_q; state_d = S_FIN0;
							end
						end
						W_RMHI: begin
							if (!(v > a_q) || last_el) begin
								cnt_d = CNT_W'(idx_s1) + CNT_W'(1); state_d = S_FIN0;
							end
						end
						W_RMV: begin
							if (ph_q) begin
								st_we = 1'b1; st_waddr = idx_s1 - IDX_W'(1); st_wdata = v;
							end else if (v == a_q) begin
								ph_d = 1'b1;
							end
							if (last_el) begin
								if (ph_q || v == a_q) begin
									cnt_d = cnt_q - CNT_W'(1);
									emp_d = (cnt_q == CNT_W'(1));
								end
								state_d = S_FIN0;
							end
						end
						W_HAS: begin
							if (v == a_q) begin
								found_d = 1'b1; state_d = S_FIN0;
							end else if (last_el) begin
								state_d = S_FIN0;
							end
						end
						W_RUN: begin
							if (v < a_q) begin
							end else if (v > b_q) begin
								if (open_q && (a_q < start_q || prev_q < b_q)) begin
									add_en = 1'b1; add_lo = start_q; add_hi = prev_q;
								end
								open_d = 1'b0; brk = 1'b1; state_d = S_FIN0;
							end else if (!open_q) begin
								start_d = v; open_d = 1'b1;
							end else if (gap) begin
								add_en = 1'b1; add_lo = start_q; add_hi = prev_q;
								start_d = v;
							end
							if (!brk && last_el) state_d = S_RUNEND;
						end
						default: begin
							state_d = S_FIN0;
						end
					endcase
				end
			end
			S_WTAIL: begin
				st_we = 1'b1; st_waddr = '0; st_wdata = a_q;
				cnt_d = cnt_q + CNT_W'(1); emp_d = 1'b0;
				state_d = S_FIN0;
			end
			S_RUNEND: begin
				if (open_q && (a_q < start_q || hi_q < b_q)) begin
					add_en = 1'b1; add_lo = start_q;
					add_hi = (hi_q < b_q) ? hi_q : b_q;
				end
				state_d = S_FIN0;
			end
			S_FIN0: begin
				if (!mode_q && !emp_q) begin
					st_raddr = '0; state_d = S_FIN1;
				end else begin
					state_d = S_EMRD;
				end
			end
			S_FIN1: begin
				st_raddr = IDX_W'(cnt_q - CNT_W'(1));
				lo_d = v; state_d = S_FIN2;
			end
			S_FIN2: begin
				hi_d = v; state_d = S_EMRD;
			end
			S_EMRD: begin
				state_d = S_EMLD;
			end
			S_EMLD: begin
				if (!ov_q || rsp.ready) begin
					load = 1'b1;
					if (last_w) begin
						state_d = S_IDLE;
					end else begin
						e_d = e_q + RA_W'(1); state_d = S_EMRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		rn_we = add_en && (rn_q < RN_W'(MAX_RESULTS));
		rn_wdata = {add_lo, add_hi};
		if (add_en && rn_q != RN_W'(MAX_RESULTS + 1)) rn_d = rn_q + RN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; wop_q <= W_INS; cmd_q <= '0;
			mode_q <= 1'b1; emp_q <= 1'b0; lo_q <= '0; hi_q <= '0; cnt_q <= '0;
			over_q <= 1'b0; found_q <= 1'b0; fwd_q <= 1'b0; rd_on_q <= 1'b0;
			ph_q <= 1'b0; open_q <= 1'b0; skip_q <= 1'b0; vld_s1 <= 1'b0;
			rd_idx_q <= '0; k_q <= '0; rn_q <= '0; e_q <= '0; ov_q <= 1'b0;
		end else begin
			state_q <= state_d; wop_q <= wop_d; cmd_q <= cmd_d;
			mode_q <= mode_d; emp_q <= emp_d; lo_q <= lo_d; hi_q <= hi_d; cnt_q <= cnt_d;
			over_q <= over_d; found_q <= found_d; fwd_q <= fwd_d; rd_on_q <= rd_on_d;
			ph_q <= ph_d; open_q <= open_d; skip_q <= skip_d; vld_s1 <= vld_d;
			rd_idx_q <= rd_idx_d; k_q <= k_d; rn_q <= rn_d; e_q <= e_d;
			if (load) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_d; b_q <= b_d; fv_q <= fv_d; start_q <= start_d; prev_q <= prev_d;
		idx_s1 <= idx_d;
		if (load) begin
			o_status <= over_w ? ST_OVER : (emp_q ? ST_EMPTY : ST_OK);
			o_found  <= found_q;
			o_mode   <= mode_q;
			o_lo     <= emp_q ? '0 : lo_q;
			o_hi     <= emp_q ? '0 : hi_q;
			o_size   <= emp_q ? '0 : (mode_q ? size_w : SIZE_W'(cnt_q));
			o_rv     <= (rn_q != '0);
			o_rlo    <= (rn_q != '0) ? value_t'(rn_rdata[2*VALUE_BITS-1:VALUE_BITS]) : '0;
			o_rhi    <= (rn_q != '0) ? value_t'(rn_rdata[VALUE_BITS-1:0]) : '0;
			o_last   <= last_w;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = o_status;
	assign rsp.found       = o_found;
	assign rsp.is_interval = o_mode;
	assign rsp.lower_bound = o_lo;
	assign rsp.upper_bound = o_hi;
	assign rsp.domain_size = o_size;
	assign rsp.run_valid   = o_rv;
	assign rsp.run_low     = o_rlo;
	assign rsp.run_high    = o_rhi;
	assign rsp.last        = o_last;

	ids_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	ids_ram #(.WIDTH(2 * VALUE_BITS), .DEPTH(MAX_RESULTS)) u_runs (
		.clk(clk), .we(rn_we), .waddr(rn_q[RA_W-1:0]), .wdata(rn_wdata),
		.raddr(e_q), .rdata(rn_rdata)
	);

`ifndef SYNTHESIS
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("value count exceeds capacity");
	a_store_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !mode_q && !emp_q) |-> cnt_q != '0)
		else $error("live store holds no values");
	a_store_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !mode_q && emp_q) |-> cnt_q == '0)
		else $error("emptied store still counts values");
	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && vld_s1) |-> CNT_W'(idx_s1) < cnt_q)
		else $error("walk reads beyond the stored values");
`endif

endmodule
